// ===== rtl/core/upd_pkg.sv =====
// Package for the form-string percent decoder: payload structs, phase codes,
// character constants and character class helpers. No dependencies.
package upd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_GROUP       = 3;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CASE_DIST  = 8'h20;   // 'a' - 'A'
    localparam logic [7:0] ALPHA_BIAS = 8'h37;   // 'A' - 10
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Up to three output bytes caused by one input word.
    typedef struct packed {
        logic [1:0]                   cnt;
        logic                         last;
        logic [MAX_GROUP-1:0][7:0]    bytes;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] v;
        u = (c >= 8'h61) ? (c - CASE_DIST) : c;
        v = (u >= 8'h41) ? (u - ALPHA_BIAS) : (u - DIGIT_BASE);
        return v[3:0];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + CASE_DIST) : c;
    endfunction

    // Output of a character that is not a percent sign, with no escape pending.
    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == PLUS_CHAR) ? SPACE_CHAR : to_lower(c);
    endfunction

endpackage

// ===== rtl/core/upd_front.sv =====
// Front end of the percent decoder: tracks the escape phase and turns each
// accepted word into a group of up to three output bytes. Uses upd_pkg.
module upd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  upd_pkg::t_in_item i_item,
    output upd_pkg::t_group   o_group
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        logic [7:0]                          c;
        logic [1:0]                          cnt;
        logic [upd_pkg::MAX_GROUP-1:0][7:0]  b;
        c       = i_item.in_byte;
        cnt     = '0;
        b       = '0;
        n_phase = r_phase;
        n_held  = r_held;
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (upd_pkg::is_hex(c)) begin
                    n_held  = c;
                    n_phase = upd_pkg::PH_DIG;
                end else begin
                    b[cnt] = upd_pkg::PCT_CHAR;
                    cnt    = cnt + 2'd1;
                    if (c == upd_pkg::PCT_CHAR) begin
                        n_phase = upd_pkg::PH_PCT;
                    end else begin
                        b[cnt]  = upd_pkg::plain_map(c);
                        cnt     = cnt + 2'd1;
                        n_phase = upd_pkg::PH_IDLE;
                    end
                end
            end
            upd_pkg::PH_DIG: begin
                if (upd_pkg::is_hex(c)) begin
                    b[cnt]  = {upd_pkg::hex_value(r_held), upd_pkg::hex_value(c)};
                    cnt     = cnt + 2'd1;
                    n_phase = upd_pkg::PH_IDLE;
                end else begin
                    // Broken escape: emit the percent sign and the held digit.
                    b[cnt] = upd_pkg::PCT_CHAR;
                    cnt    = cnt + 2'd1;
                    b[cnt] = upd_pkg::to_lower(r_held);
                    cnt    = cnt + 2'd1;
                    if (c == upd_pkg::PCT_CHAR) begin
                        n_phase = upd_pkg::PH_PCT;
                    end else begin
                        b[cnt]  = upd_pkg::plain_map(c);
                        cnt     = cnt + 2'd1;
                        n_phase = upd_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                if (c == upd_pkg::PCT_CHAR) begin
                    n_phase = upd_pkg::PH_PCT;
                end else begin
                    b[cnt]  = upd_pkg::plain_map(c);
                    cnt     = cnt + 2'd1;
                    n_phase = upd_pkg::PH_IDLE;
                end
            end
        endcase

        if (i_item.in_last) begin
            // Flush whatever escape is still pending.
            if (n_phase == upd_pkg::PH_PCT) begin
                b[cnt] = upd_pkg::PCT_CHAR;
                cnt    = cnt + 2'd1;
            end else if (n_phase == upd_pkg::PH_DIG) begin
                b[cnt] = upd_pkg::PCT_CHAR;
                cnt    = cnt + 2'd1;
                b[cnt] = upd_pkg::to_lower(n_held);
                cnt    = cnt + 2'd1;
            end
            n_phase = upd_pkg::PH_IDLE;
            n_held  = '0;
        end

        o_group.cnt   = cnt;
        o_group.last  = i_item.in_last;
        o_group.bytes = b;
    end

endmodule

// ===== rtl/core/upd_queue.sv =====
// Short group queue between front and back end of the percent decoder.
// Uses upd_pkg for the group and status types.
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  upd_pkg::t_group    i_wr_group,
    input  logic               i_rd,
    output upd_pkg::t_group    o_rd_group,
    output upd_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rd_group     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

endmodule

// ===== rtl/core/upd_back.sv =====
// Back end of the percent decoder: holds one group and hands its bytes out
// one byte per pop. Uses upd_pkg for the group and output types.
module upd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upd_pkg::t_q_status i_q_status,
    input  upd_pkg::t_group    i_group,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output upd_pkg::t_out_item o_item
);

    logic            r_valid;
    upd_pkg::t_group r_group;
    logic [1:0]      r_idx;
    logic            w_final, w_done, w_load;

    assign w_final = (r_idx == (r_group.cnt - 2'd1));
    assign w_done  = r_valid && i_pop && w_final;
    assign w_load  = (!r_valid || w_done) && !i_q_status.empty;
    assign o_q_rd  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_done) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (r_valid && i_pop) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_group <= i_group;
        end
    end

    assign o_empty         = !r_valid;
    assign o_item.out_byte = r_group.bytes[r_idx];
    assign o_item.out_last = r_group.last && w_final;

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// Top level of the streaming form-string percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage:
//   Input channel: drive i_in_item and raise push; a word is taken at a clock
//   edge with push high and full low. One character per word, in_last on the
//   final character of a string.
//   Result channel: while empty is low, o_out_item shows the oldest decoded
//   byte; it is taken at an edge with pop high. out_last marks the final
//   byte of a string.
//   Path: the front end writes each accepted word's group into the queue,
//   and the back end loads it from there once its output stage is free.
//   Throughput: one input word per cycle while full is low; the result
//   port moves one byte per cycle while pop is high, and a pending percent
//   sign or hex digit yields no byte.
//   The group queue (QUEUE_DEPTH groups) absorbs the difference.
//   Stall: when pop stays low the current result holds, the queue fills and
//   full rises; push is then ignored until a group drains.
//   Reset (synchronous, active low): escape phase clears, queue and output
//   stage empty; no result is lost or repeated across a stall.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  upd_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output upd_pkg::t_out_item o_out_item
);

    upd_pkg::t_group    w_front_group;
    upd_pkg::t_group    w_q_group;
    upd_pkg::t_q_status w_q_status;
    logic               w_accept;
    logic               w_q_wr;
    logic               w_q_rd;

    // Take a word whenever the queue has room; drop groups that carry no byte.
    assign full     = w_q_status.full;
    assign w_accept = push && !w_q_status.full;
    assign w_q_wr   = w_accept && (w_front_group.cnt != 2'd0);

    upd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_in_item),
        .o_group (w_front_group)
    );

    upd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_group(w_front_group),
        .i_rd      (w_q_rd),
        .o_rd_group(w_q_group),
        .o_status  (w_q_status)
    );

    // Advance one byte per pop, reloading from the queue on a group's last byte.
    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(w_q_status),
        .i_group   (w_q_group),
        .o_q_rd    (w_q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

// ===== rtl/core/upd_checker.sv =====
// Port-level checker for the percent decoder, bound to the top level.
// Depends on upd_pkg for the payload types.
module upd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input upd_pkg::t_out_item o_out_item
);

    // Reset leaves no result waiting and room for input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full flag present after reset");

    // A waiting result that is not taken holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("stalled result changed");

    // The queue can only fill while the output stage holds a result.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full while output stage is empty");

    // With no word taken at this sample or the last one, an idle block stays idle.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(empty) && empty && !$past(push && !full)
         && !(push && !full)) |=> empty)
        else $error("result appeared without input");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .o_out_item(o_out_item)
);
